/* sv/rank_by_value_assert.svh */
// assertion macros for the rank_by_value block
`ifndef RANK_BY_VALUE_ASSERT_SVH
`define RANK_BY_VALUE_ASSERT_SVH

// same-cycle implication, held off during reset
`define RBV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define RBV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rbv_pkg.sv */
`timescale 1ns / 1ps

package rbv_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT
  } state_t;

endpackage

/* sv/rbv_in_if.sv */
`timescale 1ns / 1ps

interface rbv_in_if;
  logic          valid;
  logic          ready;
  rbv_pkg::value_t value;
  logic          last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

/* sv/rbv_out_if.sv */
`timescale 1ns / 1ps

interface rbv_out_if;
  logic         valid;
  logic         ready;
  rbv_pkg::rank_t rank;
  logic         last_res;
  logic         overflow;

  modport source (output valid, output rank, output last_res, output overflow, input ready);
  modport sink (input valid, input rank, input last_res, input overflow, output ready);
endinterface

/* sv/rank_by_value.sv */
`timescale 1ns / 1ps
// channel   | direction | payload                     | transfer when
// ----------+-----------+-----------------------------+--------------------
// items     | in        | value (s32), last           | valid && ready
// results   | out       | rank (u6), last_res, overflow | valid && ready
//
// loading takes one cycle per item; items are refused while a set is ranked
// each rank steps through one pivot read, then n compare reads (n = stored count)
// through the single read port of the value memory, then one tail, one emit
// reset clears state, count and overflow flag; the memory is not cleared
// an output stall holds the block in its emit step with the result held

`include "rank_by_value_assert.svh"

module rank_by_value #(
  parameter int MAX_COUNT = 64
) (
  input logic       clk,
  input logic       rst,
  rbv_in_if.sink    items,
  rbv_out_if.source results
);

  localparam int IDX_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_COUNT + 1);

  rbv_pkg::state_t state;
  rbv_pkg::state_t state_next;

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [IDX_W-1:0] idx_i;
  logic [IDX_W-1:0] idx_j;
  logic             pivot_pend;
  logic             cmp_pend;
  rbv_pkg::value_t  pivot;
  rbv_pkg::rank_t   acc;
  rbv_pkg::value_t  rd_data;
  rbv_pkg::value_t  mem [MAX_COUNT];

  logic             accept;
  logic             store;
  logic             out_free;
  logic             load_out;
  logic             last_idx;
  logic             scan_end;
  logic [IDX_W-1:0] rd_addr;

  assign accept   = items.valid && items.ready;
  assign store    = accept && (count < CNT_W'(MAX_COUNT));
  assign out_free = !results.valid || results.ready;
  assign last_idx = (CNT_W'(idx_i) + CNT_W'(1)) == count;
  assign scan_end = (CNT_W'(idx_j) + CNT_W'(1)) == count;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rbv_pkg::ST_LOAD: begin
        if (accept && items.last) begin
          state_next = rbv_pkg::ST_FETCH;
        end
      end
      rbv_pkg::ST_FETCH: state_next = rbv_pkg::ST_SCAN;
      rbv_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = rbv_pkg::ST_TAIL;
        end
      end
      rbv_pkg::ST_TAIL: state_next = rbv_pkg::ST_EMIT;
      rbv_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = last_idx ? rbv_pkg::ST_LOAD : rbv_pkg::ST_FETCH;
        end
      end
      default: state_next = rbv_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    items.ready = 1'b0;
    rd_addr     = idx_j;
    load_out    = 1'b0;
    case (state)
      rbv_pkg::ST_LOAD:  items.ready = 1'b1;
      rbv_pkg::ST_FETCH: rd_addr = idx_i;
      rbv_pkg::ST_EMIT:  load_out = out_free;
      default: begin
        rd_addr = idx_j;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rbv_pkg::ST_LOAD;
      count         <= '0;
      ovf           <= 1'b0;
      idx_i         <= '0;
      idx_j         <= '0;
      pivot_pend    <= 1'b0;
      cmp_pend      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      state      <= state_next;
      pivot_pend <= (state == rbv_pkg::ST_FETCH);
      cmp_pend   <= (state == rbv_pkg::ST_SCAN);
      if (store) begin
        count <= count + CNT_W'(1);
      end else if (accept) begin
        ovf <= 1'b1;
      end
      if (state == rbv_pkg::ST_FETCH) begin
        idx_j <= '0;
      end else if (state == rbv_pkg::ST_SCAN) begin
        idx_j <= idx_j + IDX_W'(1);
      end
      if (load_out) begin
        results.valid <= 1'b1;
        if (last_idx) begin
          count <= '0;
          ovf   <= 1'b0;
          idx_i <= '0;
        end else begin
          idx_i <= idx_i + IDX_W'(1);
        end
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  // value memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (store) begin
      mem[count[IDX_W-1:0]] <= items.value;
    end
    rd_data <= mem[rd_addr];
  end

  // pivot capture and compare count
  always_ff @(posedge clk) begin
    if (pivot_pend) begin
      pivot <= rd_data;
    end
    if (state == rbv_pkg::ST_FETCH) begin
      acc <= '0;
    end else if (cmp_pend && (rd_data < pivot)) begin
      acc <= acc + rbv_pkg::RANK_W'(1);
    end
    if (load_out) begin
      results.rank     <= acc;
      results.last_res <= last_idx;
      results.overflow <= ovf;
    end
  end

  `RBV_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_W'(MAX_COUNT), "element count beyond capacity")
  `RBV_ASSERT_NOW(a_rank_below_count, load_out, CNT_W'(acc) < count, "rank not below set size")
  `RBV_ASSERT_NEXT(a_set_cleared, load_out && last_idx, count == '0 && !ovf, "set not cleared after final rank")

endmodule

/* tb/rank_by_value_tb.sv */
`timescale 1ns / 1ps

module rank_by_value_tb;

  localparam int CAPACITY = 64;
  localparam int ITEM_TARGET = 350;

  typedef struct packed {
    rbv_pkg::rank_t rank;
    logic           last_res;
    logic           overflow;
  } rank_result_t;

  class rank_scoreboard #(int DEPTH = 64);
    rbv_pkg::value_t stored[DEPTH];
    int              count;
    bit              dropped;
    rank_result_t    pending_ranks[$];
    int              failures;

    function new();
      count = 0;
      dropped = 0;
      failures = 0;
    endfunction

    // one accepted item; a final item releases the ranks of the whole set
    function void load_value(rbv_pkg::value_t v, logic last);
      rank_result_t r;
      int smaller;
      if (count < DEPTH) begin
        stored[count] = v;
        count++;
      end else begin
        dropped = 1;
      end
      if (last) begin
        for (int i = 0; i < count; i++) begin
          smaller = 0;
          for (int j = 0; j < count; j++) begin
            if (stored[j] < stored[i]) smaller++;
          end
          r.rank = rbv_pkg::rank_t'(smaller);
          r.last_res = (i == count - 1);
          r.overflow = dropped;
          pending_ranks.push_back(r);
        end
        count = 0;
        dropped = 0;
      end
    endfunction

    function void check_rank(rbv_pkg::rank_t rank, logic last_res, logic overflow);
      rank_result_t e;
      if (pending_ranks.size() == 0) begin
        $error("unexpected rank transfer: rank %0d last_res %0b overflow %0b",
               rank, last_res, overflow);
        failures++;
        return;
      end
      e = pending_ranks.pop_front();
      if (rank !== e.rank) begin
        $error("rank: expected %0d, actual %0d", e.rank, rank);
        failures++;
      end
      if (last_res !== e.last_res) begin
        $error("last_res: expected %0b, actual %0b", e.last_res, last_res);
        failures++;
      end
      if (overflow !== e.overflow) begin
        $error("overflow: expected %0b, actual %0b", e.overflow, overflow);
        failures++;
      end
    endfunction

    function int pending();
      return pending_ranks.size();
    endfunction
  endclass

  typedef rank_scoreboard #(CAPACITY) scoreboard_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet = 1'b0;
  int   items_sent = 0;

  scoreboard_t sb = new();

  rbv_in_if  items_if ();
  rbv_out_if results_if ();

  rank_by_value #(
    .MAX_COUNT(CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .items(items_if),
    .results(results_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic rbv_pkg::value_t draw_value();
    rbv_pkg::value_t v;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      v = rbv_pkg::value_t'($urandom);
    end else if (pick < 8) begin
      v = rbv_pkg::value_t'(int'($urandom_range(0, 6)) - 3);
    end else begin
      case ($urandom_range(0, 4))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = 32'sh0000_0000;
        3: v = 32'shffff_ffff;
        default: v = 32'sh0000_0001;
      endcase
    end
    return v;
  endfunction

  task automatic send_value(rbv_pkg::value_t v, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.value <= v;
    items_if.last  <= last;
    do @(posedge clk); while (!items_if.ready);
    sb.load_value(v, last);
    items_sent++;
  endtask

  task automatic send_set(int size);
    for (int i = 0; i < size; i++) begin
      send_value(draw_value(), i == size - 1);
    end
  endtask

  task automatic wait_drained();
    items_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int size;
    int pick;
    items_if.valid = 1'b0;
    items_if.value = '0;
    items_if.last  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single-element sets at both extremes
    send_value(32'sh8000_0000, 1'b1);
    send_value(32'sh7fff_ffff, 1'b1);
    // extremes with ties
    send_value(32'sh7fff_ffff, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sh0000_0000, 1'b0);
    send_value(32'shffff_ffff, 1'b0);
    send_value(32'sh0000_0001, 1'b0);
    send_value(32'sh7fff_ffff, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sh0000_0000, 1'b1);
    // all equal
    send_value(32'sh0000_0005, 1'b0);
    send_value(32'sh0000_0005, 1'b1);
    // descending
    send_value(32'sh0000_0003, 1'b0);
    send_value(32'sh0000_0002, 1'b0);
    send_value(32'sh0000_0001, 1'b0);
    send_value(32'sh0000_0000, 1'b1);

    // hold off until the block has emitted everything
    wait_drained();

    // store exactly full, then overflow with the final two items dropped
    send_set(CAPACITY);
    send_set(CAPACITY + 2);

    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 14) size = $urandom_range(1, 8);
      else if (pick < 18) size = $urandom_range(9, 40);
      else if (pick == 18) size = CAPACITY;
      else size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      send_set(size);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int gap;
    results_if.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
      sb.check_rank(results_if.rank, results_if.last_res, results_if.overflow);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
